FILE: rtl/urlenc_pkg.sv
// ----------------------------------------------------------------------------
// urlenc_pkg
// Types and constants shared by the URL form encoder modules.
// ----------------------------------------------------------------------------
package urlenc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CharW   = 7;
  localparam int unsigned CapW    = 16;
  localparam int unsigned CountW  = 17;
  localparam int unsigned StepW   = 3;

  localparam logic [CapW-1:0]   CapReset  = 16'd256;
  localparam logic [CountW-1:0] CountMax  = 17'h1FFFF;

  localparam logic [CharW-1:0] ChPercent = 7'h25;
  localparam logic [CharW-1:0] ChPlus    = 7'h2B;
  localparam logic [CharW-1:0] ChZero    = 7'h30;

  // How one source byte is expanded by the back end.
  typedef enum logic [1:0] {
    MODE_CHAR    = 2'd0,  // one literal character
    MODE_HEX_LO  = 2'd1,  // %xx, lower-case digits
    MODE_HEX_UP  = 2'd2,  // %XX, upper-case digits
    MODE_HEX_PAD = 2'd3   // %XX%00, lead byte that ends the string
  } mode_e;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             run_last;
    logic             string_done;
    logic             fits;
  } out_item_t;

  // Classified byte handed from the front end to the back end.
  typedef struct packed {
    logic [ByteW-1:0] data;
    mode_e            mode;
    logic             eos;
    logic             fit;
  } job_t;

endpackage

FILE: rtl/urlenc_front.sv
// ----------------------------------------------------------------------------
// urlenc_front
// Accepts source bytes, classifies them and keeps the per-string state.
// ----------------------------------------------------------------------------
module urlenc_front import urlenc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  in_item_t        in_item_i,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_data_i,
  output job_t            job_o
);

  logic [CapW-1:0]   cap_q;
  logic              trail_q, trail_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW:0]   sum;
  logic [CountW-1:0] count_sat;
  logic [StepW-1:0]  n_chars;
  logic [ByteW-1:0]  c;
  logic              eos;

  function automatic logic passes(input logic [ByteW-1:0] b);
    logic r;
    r = ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h61) && (b <= 8'h7A)) ||
        ((b >= 8'h41) && (b <= 8'h5A)) || (b == 8'h5F) || (b == 8'h2D) ||
        (b == 8'h2E) || (b == 8'h2A);
    return r;
  endfunction

  assign c   = in_item_i.in_byte;
  assign eos = in_item_i.end_of_string;

  always_comb begin
    job_o.data = c;
    job_o.eos  = eos;
    job_o.mode = MODE_CHAR;
    trail_d    = 1'b0;
    n_chars    = 3'd3;
    if (trail_q) begin
      job_o.mode = MODE_HEX_UP;
    end else if (passes(c)) begin
      n_chars = 3'd1;
    end else if (c == 8'h20) begin
      job_o.data = {1'b0, ChPlus};
      n_chars    = 3'd1;
    end else if (((c >= 8'h20) && (c < 8'h7F)) || ((c >= 8'hA1) && (c < 8'hE0))) begin
      job_o.mode = MODE_HEX_LO;
    end else if (eos) begin
      job_o.mode = MODE_HEX_PAD;
      n_chars    = 3'd6;
    end else begin
      job_o.mode = MODE_HEX_UP;
      trail_d    = 1'b1;
    end

    // The count saturates, and fits compares the saturated value.
    sum       = {1'b0, count_q} + {{(CountW-StepW+1){1'b0}}, n_chars};
    count_sat = sum[CountW] ? CountMax : sum[CountW-1:0];
    job_o.fit = count_sat < {1'b0, cap_q};
    count_d   = eos ? '0 : count_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CapReset;
      trail_q <= 1'b0;
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (accept_i) begin
        trail_q <= trail_d;
        count_q <= count_d;
      end
    end
  end

endmodule

FILE: rtl/urlenc_fifo.sv
// ----------------------------------------------------------------------------
// urlenc_fifo
// Short queue of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
module urlenc_fifo import urlenc_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/urlenc_back.sv
// ----------------------------------------------------------------------------
// urlenc_back
// Expands classified bytes into encoded characters in a result register,
// one per cycle while that register is free or being popped.
// ----------------------------------------------------------------------------
module urlenc_back import urlenc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      job_pop_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t out_item_o
);

  logic [StepW-1:0] step_q, step_d;
  logic [StepW-1:0] last_step;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;
  logic             load, is_last, upper;

  function automatic logic [CharW-1:0] hex_digit(input logic [3:0] nib, input logic up);
    logic [CharW-1:0] r;
    if (nib < 4'd10) begin
      r = 7'h30 + {3'b000, nib};
    end else begin
      r = (up ? 7'h37 : 7'h57) + {3'b000, nib};
    end
    return r;
  endfunction

  always_comb begin
    case (job_i.mode)
      MODE_CHAR:    last_step = 3'd0;
      MODE_HEX_LO:  last_step = 3'd2;
      MODE_HEX_UP:  last_step = 3'd2;
      MODE_HEX_PAD: last_step = 3'd5;
      default:      last_step = 3'd0;
    endcase
    upper   = (job_i.mode != MODE_HEX_LO);
    is_last = (step_q == last_step);
    // A new character goes into the result register when it is free or
    // being emptied in this cycle.
    load    = job_valid_i && (!out_valid_q || pop_i);

    out_d.run_last    = is_last;
    out_d.string_done = is_last && job_i.eos;
    out_d.fits        = is_last && job_i.eos && job_i.fit;
    case (step_q)
      3'd0:    out_d.out_char = (job_i.mode == MODE_CHAR) ? job_i.data[CharW-1:0]
                                                          : ChPercent;
      3'd1:    out_d.out_char = hex_digit(job_i.data[7:4], upper);
      3'd2:    out_d.out_char = hex_digit(job_i.data[3:0], upper);
      3'd3:    out_d.out_char = ChPercent;
      default: out_d.out_char = ChZero;
    endcase

    step_d      = step_q;
    out_valid_d = out_valid_q;
    job_pop_o   = 1'b0;
    if (load) begin
      out_valid_d = 1'b1;
      if (is_last) begin
        step_d    = '0;
        job_pop_o = 1'b1;
      end else begin
        step_d = step_q + 1'b1;
      end
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

endmodule

FILE: rtl/url_percent_encoder_sjis.sv
// ----------------------------------------------------------------------------
// url_percent_encoder_sjis
// URL form encoder for double-byte strings, front end, queue and back end.
//
//   channel   handshake            payload
//   input     push / full          in_item_i  (in_byte, end_of_string)
//   result    empty / pop          out_item_o (out_char, run_last,
//                                              string_done, fits)
//   config    cfg_valid_i / _o     cfg_data_i (out_capacity)
//
// The front end classifies a byte in the cycle it is accepted and queues it.
// The back end emits one character per cycle while results are popped, so a
// byte becomes 1, 3 or 6 characters; that sequencer sets the sustained rate.
// Input is taken every cycle while the queue has room, independent of pop.
// Reset clears the per-string state and sets the capacity to 256.
// ----------------------------------------------------------------------------
module url_percent_encoder_sjis import urlenc_pkg::*; #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  in_item_t        in_item_i,
  output logic            empty,
  input  logic            pop,
  output out_item_t       out_item_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CapW-1:0] cfg_data_i
);

  job_t job_in, job_out;
  logic accept, job_empty, job_pop;

  assign accept      = push && !full;
  assign cfg_ready_o = 1'b1;

  urlenc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_item_i (in_item_i),
    .cfg_we_i  (cfg_valid_i),
    .cfg_data_i(cfg_data_i),
    .job_o     (job_in)
  );

  urlenc_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(job_in),
    .full_o (full),
    .pop_i  (job_pop),
    .empty_o(job_empty),
    .rdata_o(job_out)
  );

  urlenc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(!job_empty),
    .job_i      (job_out),
    .job_pop_o  (job_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

endmodule
